// ----- hw/rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and header constants for the arp cache table.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // arp header values that a frame must carry to be learnt
    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [7:0]  MAC_BYTES    = 8'd6;
    localparam logic [7:0]  IP_BYTES     = 8'd4;
    localparam logic [15:0] OP_REPLY     = 16'h0002;

    // input item widths
    localparam int IN_DATA_W  = 192;
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;

    // outcome of a frame beat
    typedef enum logic [1:0] {
        ACT_IGNORED  = 2'd0,
        ACT_UPDATED  = 2'd1,
        ACT_INSERTED = 2'd2,
        ACT_FULL     = 2'd3
    } t_action;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // one input item
    typedef struct packed {
        logic        mode;
        logic [15:0] frame_type;
        logic [15:0] hw_kind;
        logic [15:0] proto_kind;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] arp_op;
        logic [31:0] sender_ip;
        logic [47:0] sender_hw;
        logic [31:0] query_ip;
    } t_item;

    // one result, apart from the entry count
    typedef struct packed {
        logic        hit;
        logic [47:0] found_mac;
        t_action     action;
    } t_result;

    // write enables towards the store
    typedef struct packed {
        logic ip_en;
        logic mac_en;
    } t_wr_en;

endpackage

// ----- hw/rtl/arp_cache_table.sv -----
// ----------------------------------------------------------------------------
// arp_cache_table
// ARP cache mapping IPv4 addresses to MAC addresses, learning from replies
// and answering lookups.
// ----------------------------------------------------------------------------
// Each input beat is a received arp header (tuser 0) or a lookup (tuser 1)
// and yields one result beat. Entries are compared one per clock through a
// single comparator reading a registered-output memory; the scan stops at the
// first match or after the last valid entry, and a malformed or non-reply
// frame is not scanned at all. The input is taken only while the sequencer is
// idle; a finished result waits in the output register. Replies update the
// first entry with the same address, or append a new one, or are dropped when
// the table is full. The table is empty after reset and needs no clearing.
// ----------------------------------------------------------------------------
module arp_cache_table #(
    parameter int ENTRIES = 16,
    localparam int CNT_W  = $clog2(ENTRIES + 1),
    localparam int OUT_W  = ((48 + 2 + CNT_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // frame_type, hw_kind, proto_kind, hw_len, proto_len, arp_op,
    // sender_ip, sender_hw, query_ip
    input  logic [191:0]        s_axis_tdata,
    // mode
    input  logic [0:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // found_mac, action, used_entries, zero padding
    output logic [OUT_W-1:0]    m_axis_tdata,
    // hit
    output logic [0:0]          m_axis_tuser
);
    import arpc_pkg::*;

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAD_W  = OUT_W - (MAC_W + 2 + CNT_W);

    t_item              in_item;
    logic               res_ready;
    logic               res_valid;
    t_result            res;
    logic [CNT_W-1:0]   res_count;
    logic [ADDR_W-1:0]  rd_addr;
    logic [IP_W-1:0]    rd_ip;
    logic [MAC_W-1:0]   rd_mac;
    t_wr_en             wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [IP_W-1:0]    wr_ip;
    logic [MAC_W-1:0]   wr_mac;

    logic               r_out_valid;
    t_result            r_out;
    logic [CNT_W-1:0]   r_out_count;

    // unpack the input beat
    assign in_item.mode       = s_axis_tuser[0];
    assign in_item.frame_type = s_axis_tdata[15:0];
    assign in_item.hw_kind    = s_axis_tdata[31:16];
    assign in_item.proto_kind = s_axis_tdata[47:32];
    assign in_item.hw_len     = s_axis_tdata[55:48];
    assign in_item.proto_len  = s_axis_tdata[63:56];
    assign in_item.arp_op     = s_axis_tdata[79:64];
    assign in_item.sender_ip  = s_axis_tdata[111:80];
    assign in_item.sender_hw  = s_axis_tdata[159:112];
    assign in_item.query_ip   = s_axis_tdata[191:160];

    // the sequencer may finish once the output register is free
    assign res_ready = !r_out_valid || m_axis_tready;

    arpc_seq #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W),
        .CNT_W   (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (in_item),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_count     (res_count),
        .o_rd_addr   (rd_addr),
        .i_rd_ip     (rd_ip),
        .i_rd_mac    (rd_mac),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_ip     (wr_ip),
        .o_wr_mac    (wr_mac)
    );

    arpc_store #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_ip   (wr_ip),
        .i_wr_mac  (wr_mac),
        .i_rd_addr (rd_addr),
        .o_rd_ip   (rd_ip),
        .o_rd_mac  (rd_mac)
    );

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out       <= res;
            r_out_count <= res_count;
        end
    end

    // pack the output beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.hit;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_count, r_out.action, r_out.found_mac};

endmodule

// ----- hw/rtl/arpc_store.sv -----
// ----------------------------------------------------------------------------
// arpc_store
// Address/MAC pair memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module arpc_store #(
    parameter int ENTRIES = 16,
    parameter int ADDR_W  = 4
) (
    input  logic                  i_clk,
    input  arpc_pkg::t_wr_en      i_wr_en,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [31:0]           i_wr_ip,
    input  logic [47:0]           i_wr_mac,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic [31:0]           o_rd_ip,
    output logic [47:0]           o_rd_mac
);
    import arpc_pkg::*;

    logic [IP_W-1:0]  r_ip_mem  [ENTRIES];
    logic [MAC_W-1:0] r_mac_mem [ENTRIES];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en.ip_en) begin
            r_ip_mem[i_wr_addr] <= i_wr_ip;
        end
        if (i_wr_en.mac_en) begin
            r_mac_mem[i_wr_addr] <= i_wr_mac;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_ip  <= r_ip_mem[i_rd_addr];
        o_rd_mac <= r_mac_mem[i_rd_addr];
    end

endmodule

// ----- hw/rtl/arpc_seq.sv -----
// ----------------------------------------------------------------------------
// arpc_seq
// Sequencer: header check, pipelined scan of valid entries through one
// comparator, then update, insert or drop and result hand-off.
// ----------------------------------------------------------------------------
module arpc_seq #(
    parameter int ENTRIES = 16,
    parameter int ADDR_W  = 4,
    parameter int CNT_W   = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  arpc_pkg::t_item       i_item,
    input  logic                  i_res_ready,
    output logic                  o_res_valid,
    output arpc_pkg::t_result     o_res,
    output logic [CNT_W-1:0]      o_count,
    output logic [ADDR_W-1:0]     o_rd_addr,
    input  logic [31:0]           i_rd_ip,
    input  logic [47:0]           i_rd_mac,
    output arpc_pkg::t_wr_en      o_wr_en,
    output logic [ADDR_W-1:0]     o_wr_addr,
    output logic [31:0]           o_wr_ip,
    output logic [47:0]           o_wr_mac
);
    import arpc_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx,   n_idx;
    logic               r_pend,  n_pend;
    logic [ADDR_W-1:0]  r_pidx,  n_pidx;
    logic               r_match, n_match;
    logic [ADDR_W-1:0]  r_midx,  n_midx;
    logic [MAC_W-1:0]   r_mmac,  n_mmac;
    logic               r_mode,  n_mode;
    logic               r_ok,    n_ok;
    logic [IP_W-1:0]    r_key,   n_key;
    logic [MAC_W-1:0]   r_hw,    n_hw;
    logic               hdr_ok;

    // header check on the incoming beat
    assign hdr_ok = (i_item.frame_type == ETH_TYPE_ARP)
                 && (i_item.hw_kind    == HW_ETHERNET)
                 && (i_item.proto_kind == PROTO_IPV4)
                 && (i_item.hw_len     == MAC_BYTES)
                 && (i_item.proto_len  == IP_BYTES)
                 && (i_item.arp_op     == OP_REPLY);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_match <= n_match;
        r_midx  <= n_midx;
        r_mmac  <= n_mmac;
        r_mode  <= n_mode;
        r_ok    <= n_ok;
        r_key   <= n_key;
        r_hw    <= n_hw;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_match     = r_match;
        n_midx      = r_midx;
        n_mmac      = r_mmac;
        n_mode      = r_mode;
        n_ok        = r_ok;
        n_key       = r_key;
        n_hw        = r_hw;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{hit: 1'b0, found_mac: '0, action: ACT_IGNORED};
        o_rd_addr   = r_idx[ADDR_W-1:0];
        o_wr_en     = '{ip_en: 1'b0, mac_en: 1'b0};
        o_wr_addr   = r_count[ADDR_W-1:0];
        o_wr_ip     = r_key;
        o_wr_mac    = r_hw;

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_mode  = i_item.mode;
                    n_ok    = hdr_ok;
                    n_key   = i_item.mode ? i_item.query_ip : i_item.sender_ip;
                    n_hw    = i_item.sender_hw;
                    n_idx   = '0;
                    n_match = 1'b0;
                    n_state = (i_item.mode || hdr_ok) ? ST_SCAN : ST_DONE;
                end
            end

            // one address issued per cycle, previous read compared
            ST_SCAN: begin
                if (r_pend && (i_rd_ip == r_key)) begin
                    n_match = 1'b1;
                    n_midx  = r_pidx;
                    n_mmac  = i_rd_mac;
                    n_state = ST_DONE;
                end else if (r_idx < r_count) begin
                    n_pend  = 1'b1;
                    n_pidx  = r_idx[ADDR_W-1:0];
                    n_idx   = r_idx + 1'b1;
                end else begin
                    n_state = ST_DONE;
                end
            end

            // apply the outcome and hand the result over
            ST_DONE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_mode) begin
                        o_res.hit       = r_match;
                        o_res.found_mac = r_match ? r_mmac : '0;
                    end else if (r_ok) begin
                        if (r_match) begin
                            o_wr_en.mac_en = 1'b1;
                            o_wr_addr      = r_midx;
                            o_res.action   = ACT_UPDATED;
                        end else if (r_count < FULL_CNT) begin
                            o_wr_en.ip_en  = 1'b1;
                            o_wr_en.mac_en = 1'b1;
                            n_count        = r_count + 1'b1;
                            o_res.action   = ACT_INSERTED;
                        end else begin
                            o_res.action   = ACT_FULL;
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_count = n_count;

endmodule
